[sv/bpc_pkg.sv]
// package for the barometric pressure compensation block
// holds the scale table, widths and the saturation helper; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

    localparam int QW = 64;     // internal fixed-point word, 24 fraction bits
    localparam int RAW_W = 24;
    localparam int SCW = 31;    // scaled value fits in 31 signed bits

    localparam logic signed [QW-1:0] LIM_Q = 64'sd35184372088832;

    localparam int OUT_W = 64;  // tdata width: 32 + 24 = 56 -> 7 bytes, pad to 64

    typedef enum logic [2:0] {
        REG_COEF_A  = 3'd0,
        REG_COEF_B  = 3'd1,
        REG_COEF_C  = 3'd2,
        REG_P_OSR   = 3'd3,
        REG_T_OSR   = 3'd4
    } reg_idx_t;

    function automatic logic [22:0] scale_lookup(input logic [2:0] code);
        logic [22:0] r;
        unique case (code)
            3'd0: r = 23'd524288;
            3'd1: r = 23'd1572864;
            3'd2: r = 23'd3670016;
            3'd3: r = 23'd7864320;
            3'd4: r = 23'd253952;
            3'd5: r = 23'd516096;
            3'd6: r = 23'd1040384;
            default: r = 23'd2088960;
        endcase
        return r;
    endfunction

    function automatic logic signed [QW-1:0] satq(input logic signed [QW-1:0] x);
        logic signed [QW-1:0] r;
        if (x > LIM_Q) r = LIM_Q;
        else if (x < -LIM_Q) r = -LIM_Q;
        else r = x;
        return r;
    endfunction

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;

endpackage
`default_nettype wire

[sv/barometric_pressure_compensation.sv]
// top level of the barometric pressure compensation block
// depends on bpc_pkg, bpc_div and bpc_mul
//
// channel  dir  beat contents (lowest bit first)
// s_axis   in   tuser: temp_ready, press_ready; tdata: temp_reading, press_reading
// m_axis   out  tuser: temp_ready_echo, press_ready_echo;
//               tdata: pressure_fixed, temperature_fixed, zero pad
// cfg      in   wr_en, wr_idx, wr_data (one register per write)
//
// one beat runs from accept to next accept with a free output through:
// the accept cycle, two serial divides (start, 48 quotient bits, done),
// eight digit-serial multiplies (start, 8 digits, done) on a
// single shared multiplier, a finish cycle and the output load cycle
// reset clears the held raw readings, coefficients and codes (codes to 4)
// a finished result sits in the output register; a new beat is taken while
// it waits, but the next result waits for the output to drain
`timescale 1ns / 1ps
`default_nettype none
module barometric_pressure_compensation (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // temp_reading, press_reading
    input  wire logic [1:0]  s_axis_tuser,  // temp_ready, press_ready
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // pressure_fixed, temperature_fixed, pad
    output logic [1:0]       m_axis_tuser,  // temp_ready_echo, press_ready_echo
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_idx,
    input  wire logic [63:0] wr_data
);
    import bpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVT, S_DIVP, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_M6, S_M7, S_M8, S_FIN, S_HOLD
    } state_t;

    state_t state_reg;
    logic [63:0] wa_reg, wb_reg;
    logic [15:0] wc_reg;
    logic [2:0]  posr_reg, tosr_reg;
    logic [23:0] ht_reg, hp_reg;
    logic [1:0]  flg_reg;
    logic signed [QW-1:0] st_reg, sp_reg, h_reg, g_reg, t_reg, acc_reg;
    logic        mwait_reg;
    logic        dwait_reg;
    logic        ov_reg;
    logic [63:0] od_reg;
    logic [1:0]  ou_reg;
    logic        out_load;

    // coefficients
    logic signed [11:0] c0, c1;
    logic signed [19:0] c00, c10;
    logic signed [15:0] c01, c11, c20, c21, c30;
    assign c0  = wa_reg[63:52];
    assign c1  = wa_reg[51:40];
    assign c00 = wa_reg[39:20];
    assign c10 = wa_reg[19:0];
    assign c01 = wb_reg[63:48];
    assign c11 = wb_reg[47:32];
    assign c20 = wb_reg[31:16];
    assign c21 = wb_reg[15:0];
    assign c30 = wc_reg;

    // shared divider
    logic div_start, div_done;
    logic signed [RAW_W-1:0] div_raw;
    logic [22:0] div_den;
    logic signed [QW-1:0] div_q;
    bpc_div u_div (.clk, .rst_n, .start(div_start), .raw(div_raw), .divisor(div_den),
                   .done(div_done), .quot(div_q));

    // shared multiplier
    logic mul_start, mul_done;
    logic signed [QW-1:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [95:0] mul_p;
    bpc_mul u_mul (.clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
                   .done(mul_done), .prod(mul_p));

    logic signed [QW-1:0] prod64, q24prod;
    assign prod64 = mul_p[63:0];
    // q24 product: floor(a*s / 2^24), saturated
    assign q24prod = satq(mul_p[87:24]);

    logic signed [QW-1:0] c0h, tsh, psh;
    assign c0h = QW'((c0 / 12'sd2)) <<< 24;
    assign tsh = t_reg >>> 16;
    assign psh = acc_reg >>> 18;

    always_comb
    begin
        div_start = 1'b0;
        div_raw = ht_reg;
        div_den = scale_lookup(tosr_reg);
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_DIVP)
        begin
            div_raw = hp_reg;
            div_den = scale_lookup(posr_reg);
        end
        unique case (state_reg)
            S_M1: begin mul_a = QW'(c30); mul_b = sp_reg[31:0]; end
            S_M2: begin mul_a = h_reg;    mul_b = sp_reg[31:0]; end
            S_M3: begin mul_a = h_reg;    mul_b = sp_reg[31:0]; end
            S_M4: begin mul_a = QW'(c21); mul_b = sp_reg[31:0]; end
            S_M5: begin mul_a = g_reg;    mul_b = sp_reg[31:0]; end
            S_M6: begin mul_a = g_reg;    mul_b = st_reg[31:0]; end
            S_M7: begin mul_a = QW'(c01); mul_b = st_reg[31:0]; end
            S_M8: begin mul_a = QW'(c1);  mul_b = st_reg[31:0]; end
            default: ;
        endcase
        if (state_reg >= S_M1 && state_reg <= S_M8 && !mwait_reg)
            mul_start = 1'b1;
        // held readings are already updated when the divides start
        if ((state_reg == S_DIVT || state_reg == S_DIVP) && !dwait_reg)
            div_start = 1'b1;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_HOLD) && (!ov_reg || m_axis_tready);

    logic [23:0] t_in, p_in;
    assign t_in = s_axis_tdata[23:0];
    assign p_in = s_axis_tdata[47:24];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wa_reg <= '0; wb_reg <= '0; wc_reg <= '0;
            posr_reg <= 3'd4; tosr_reg <= 3'd4;
            ht_reg <= '0; hp_reg <= '0;
            flg_reg <= '0;
            st_reg <= '0; sp_reg <= '0; h_reg <= '0; g_reg <= '0;
            t_reg <= '0; acc_reg <= '0;
            mwait_reg <= 1'b0;
            dwait_reg <= 1'b0;
            ov_reg <= 1'b0;
            od_reg <= '0;
            ou_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_idx)
                    REG_COEF_A: wa_reg <= wr_data;
                    REG_COEF_B: wb_reg <= wr_data;
                    REG_COEF_C: wc_reg <= wr_data[15:0];
                    REG_P_OSR:  posr_reg <= wr_data[2:0];
                    REG_T_OSR:  tosr_reg <= wr_data[2:0];
                    default: ;
                endcase
            end
            if (out_load)
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;
            if (mul_start)
                mwait_reg <= 1'b1;
            else if (mul_done)
                mwait_reg <= 1'b0;
            if (div_start)
                dwait_reg <= 1'b1;
            else if (div_done)
                dwait_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        flg_reg <= s_axis_tuser;
                        if (s_axis_tuser[0])
                            ht_reg <= t_in;
                        if (s_axis_tuser[1])
                            hp_reg <= p_in;
                        state_reg <= S_DIVT;
                    end
                end
                S_DIVT:
                begin
                    if (div_done)
                    begin
                        st_reg <= div_q;
                        state_reg <= S_DIVP;
                    end
                end
                S_DIVP:
                begin
                    if (div_done)
                    begin
                        sp_reg <= div_q;
                        state_reg <= S_M1;
                    end
                end
                S_M1: if (mul_done)
                begin
                    h_reg <= satq((QW'(c20) <<< 24) + prod64);
                    state_reg <= S_M2;
                end
                S_M2: if (mul_done)
                begin
                    h_reg <= satq((QW'(c10) <<< 24) + q24prod);
                    state_reg <= S_M3;
                end
                S_M3: if (mul_done)
                begin
                    h_reg <= q24prod;
                    state_reg <= S_M4;
                end
                S_M4: if (mul_done)
                begin
                    g_reg <= satq((QW'(c11) <<< 24) + prod64);
                    state_reg <= S_M5;
                end
                S_M5: if (mul_done)
                begin
                    g_reg <= q24prod;
                    state_reg <= S_M6;
                end
                S_M6: if (mul_done)
                begin
                    acc_reg <= (QW'(c00) <<< 24) + h_reg + q24prod;
                    state_reg <= S_M7;
                end
                S_M7: if (mul_done)
                begin
                    acc_reg <= acc_reg + prod64;
                    state_reg <= S_M8;
                end
                S_M8: if (mul_done)
                begin
                    t_reg <= c0h + prod64;
                    state_reg <= S_FIN;
                end
                S_FIN: state_reg <= S_HOLD;
                S_HOLD:
                begin
                    if (out_load)
                    begin
                        ou_reg <= flg_reg;
                        od_reg <= {8'd0,
                            (tsh > 64'sd8388607) ? 24'h7FFFFF :
                            (tsh < -64'sd8388608) ? 24'h800000 : tsh[23:0],
                            (psh > 64'sd2147483647) ? 32'h7FFFFFFF :
                            (psh < -64'sd2147483648) ? 32'h80000000 : psh[31:0]};
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = od_reg;
    assign m_axis_tuser = ou_reg;

`ifndef SYNTH
    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_start && mwait_reg))
        else $error("multiplier restarted while running");
    a_one_div: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_start && dwait_reg))
        else $error("divider restarted while running");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

[sv/bpc_div.sv]
// bit-serial restoring divider: |raw| * 2^24 / scale, truncated toward zero
// depends on bpc_pkg
`timescale 1ns / 1ps
`default_nettype none
module bpc_div (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic signed [bpc_pkg::RAW_W-1:0] raw,
    input  wire logic [22:0] divisor,
    output logic done,
    output logic signed [bpc_pkg::QW-1:0] quot
);
    import bpc_pkg::*;

    // dividend magnitude up to 2^47, quotient up to 48 bits
    logic [47:0] dvd_reg, dvd_next;
    logic [47:0] q_reg, q_next;
    logic [23:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [23:0] trial;
    logic [24:0] diff;

    always_comb
    begin
        dvd_next = dvd_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[22:0], dvd_reg[47]};
        diff = {1'b0, trial} - {2'b0, divisor};
        if (start)
        begin
            neg_next = raw[RAW_W-1];
            dvd_next = {(raw[RAW_W-1] ? 24'(-raw) : 24'(raw)), 24'd0};
            rem_next = '0;
            q_next = '0;
            cnt_next = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            dvd_next = {dvd_reg[46:0], 1'b0};
            if (!diff[24])
            begin
                rem_next = diff[23:0];
                q_next = {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg <= q_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({16'd0, q_reg}) : $signed({16'd0, q_reg});
endmodule
`default_nettype wire

[sv/bpc_mul.sv]
// digit-serial multiplier: signed 64-bit value times signed 32-bit value,
// 4-bit digit per cycle, 96-bit product; depends on bpc_pkg
`timescale 1ns / 1ps
`default_nettype none
module bpc_mul (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic signed [bpc_pkg::QW-1:0] a,
    input  wire logic signed [31:0] b,
    output logic done,
    output logic signed [95:0] prod
);
    import bpc_pkg::*;

    logic signed [95:0] acc_reg, acc_next;
    logic signed [95:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [3:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic signed [100:0] pp;

    always_comb
    begin
        acc_next = acc_reg;
        a_next = a_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        // top digit is signed, lower digits unsigned
        if (cnt_reg == 4'd1)
            pp = a_reg * $signed({{1{b_reg[3]}}, b_reg[3:0]});
        else
            pp = a_reg * $signed({1'b0, b_reg[3:0]});
        if (start)
        begin
            acc_next = '0;
            a_next = 96'(a);
            b_next = b;
            cnt_next = 4'd8;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + 96'(pp);
            a_next = a_reg <<< 4;
            b_next = {4'd0, b_reg[31:4]};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire
